// ===== hdl/asp_pkg.sv =====
// ----------------------------------------------------------------------------
// asp_pkg: argument splitter shared types
// Result and error codes, field widths and the result record shared by the
// splitter modules and interfaces.
// ----------------------------------------------------------------------------
package asp_pkg;

  // Longest text that is parsed; later bytes raise the too-long error.
  localparam int unsigned MaxTextLen = 65536;
  localparam int unsigned IdxW       = 17;   // holds 0 .. MaxTextLen
  localparam int unsigned PosW       = 16;
  localparam int unsigned CharW      = 8;

  // Result queue sizing
  localparam int unsigned RqDepth = 8;
  localparam int unsigned RqPtrW  = 3;
  localparam int unsigned RqCntW  = 4;

  localparam logic [CharW-1:0] ChSpace   = 8'h20;
  localparam logic [CharW-1:0] ChTab     = 8'h09;
  localparam logic [CharW-1:0] ChLf      = 8'h0A;
  localparam logic [CharW-1:0] ChCr      = 8'h0D;
  localparam logic [CharW-1:0] ChQuote   = 8'h22;
  localparam logic [CharW-1:0] ChBslash  = 8'h5C;
  localparam logic [CharW-1:0] ChLParen  = 8'h28;
  localparam logic [CharW-1:0] ChRParen  = 8'h29;
  localparam logic [CharW-1:0] ChLBrack  = 8'h5B;
  localparam logic [CharW-1:0] ChRBrack  = 8'h5D;
  localparam logic [CharW-1:0] ChComma   = 8'h2C;

  typedef enum logic [1:0] {
    KIND_ARG   = 2'd0,
    KIND_ERROR = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE          = 3'd0,
    ERR_STRAY_PAREN   = 3'd1,
    ERR_STRAY_BRACKET = 3'd2,
    ERR_OPEN_STRING   = 3'd3,
    ERR_PARENS        = 3'd4,
    ERR_BRACKETS      = 3'd5,
    ERR_TOO_LONG      = 3'd6
  } err_e;

  typedef struct packed {
    kind_e            kind;
    logic [IdxW-1:0]  arg_start;
    logic [IdxW-1:0]  arg_length;
    err_e             error_code;
    logic [PosW-1:0]  error_position;
    logic             run_last;
    logic             text_last;
  } result_t;

  // Results produced by one byte, handed from parser to result queue
  typedef struct packed {
    logic [1:0] count;  // 0, 1 or 2
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

// ===== hdl/asp_if.sv =====
// ----------------------------------------------------------------------------
// asp_if: argument splitter stream interfaces
// Valid/ready channels for the byte stream and for the result stream.
// ----------------------------------------------------------------------------
interface asp_in_if import asp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] character;
  logic             has_char;
  logic             last;

  modport source (output valid, character, has_char, last, input ready);
  modport sink   (input valid, character, has_char, last, output ready);
endinterface

interface asp_out_if import asp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [1:0]      kind;
  logic [IdxW-1:0] arg_start;
  logic [IdxW-1:0] arg_length;
  logic [2:0]      error_code;
  logic [PosW-1:0] error_position;
  logic            run_last;
  logic            text_last;

  modport source (output valid, kind, arg_start, arg_length, error_code, error_position,
                  run_last, text_last, input ready);
  modport sink   (input valid, kind, arg_start, arg_length, error_code, error_position,
                  run_last, text_last, output ready);
endinterface

// ===== hdl/asp_parse.sv =====
// ----------------------------------------------------------------------------
// asp_parse: argument splitter parse state
// Holds nesting, quoting, segment and error state and turns one byte into
// zero, one or two results.
// ----------------------------------------------------------------------------
module asp_parse import asp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [CharW-1:0] char_i,
  input  logic             has_i,
  input  logic             last_i,
  output push_t            push_o
);

  typedef struct packed {
    logic [IdxW-1:0] char_index;
    logic            content_seen;
    logic [IdxW-1:0] content_first;
    logic [IdxW-1:0] content_end;
    logic [IdxW-1:0] paren_level;
    logic [IdxW-1:0] bracket_level;
    logic            inside_quotes;
    logic            escape_pending;
    err_e            err_code;
    logic [PosW-1:0] err_pos;
  } state_t;

  localparam logic [IdxW-1:0] MaxIdx = IdxW'(MaxTextLen);

  state_t st_q, st_d;

  function automatic result_t make_arg(logic seen, logic [IdxW-1:0] first,
                                       logic [IdxW-1:0] last_end,
                                       logic [IdxW-1:0] seg_end);
    result_t r;
    r = '0;
    r.kind       = KIND_ARG;
    r.error_code = ERR_NONE;
    if (seen) begin
      r.arg_start  = first;
      r.arg_length = last_end - first;
    end else begin
      r.arg_start  = seg_end;
    end
    return r;
  endfunction

  function automatic result_t make_err(err_e code, logic [PosW-1:0] pos);
    result_t r;
    r = '0;
    r.kind           = KIND_ERROR;
    r.error_code     = code;
    r.error_position = pos;
    return r;
  endfunction

  always_comb begin
    logic [IdxW-1:0] idx;
    logic            blank;
    logic            split;
    result_t         fin_r;
    idx    = st_q.char_index;
    blank  = (char_i == ChSpace) || (char_i == ChTab) || (char_i == ChLf) ||
             (char_i == ChCr);
    split  = 1'b0;
    fin_r  = '0;
    st_d   = st_q;
    push_o = '0;

    if (in_valid_i && (has_i || last_i)) begin
      if (has_i) begin
        if (idx >= MaxIdx) begin
          if (st_q.err_code == ERR_NONE) begin
            st_d.err_code = ERR_TOO_LONG;
            st_d.err_pos  = idx[PosW-1:0];
          end
        end else begin
          st_d.char_index = idx + 1'b1;
          if (st_q.err_code == ERR_NONE) begin
            if (st_q.inside_quotes) begin
              if (st_q.escape_pending) begin
                st_d.escape_pending = 1'b0;
              end else if (char_i == ChBslash) begin
                st_d.escape_pending = 1'b1;
              end else if (char_i == ChQuote) begin
                st_d.inside_quotes = 1'b0;
              end
            end else if (char_i == ChQuote) begin
              st_d.inside_quotes = 1'b1;
            end else if (char_i == ChLParen) begin
              st_d.paren_level = st_q.paren_level + 1'b1;
            end else if (char_i == ChLBrack) begin
              st_d.bracket_level = st_q.bracket_level + 1'b1;
            end else if (char_i == ChRParen) begin
              if (st_q.paren_level == '0) begin
                st_d.err_code = ERR_STRAY_PAREN;
                st_d.err_pos  = idx[PosW-1:0];
              end else begin
                st_d.paren_level = st_q.paren_level - 1'b1;
              end
            end else if (char_i == ChRBrack) begin
              if (st_q.bracket_level == '0) begin
                st_d.err_code = ERR_STRAY_BRACKET;
                st_d.err_pos  = idx[PosW-1:0];
              end else begin
                st_d.bracket_level = st_q.bracket_level - 1'b1;
              end
            end else if (char_i == ChComma && st_q.paren_level == '0 &&
                         st_q.bracket_level == '0) begin
              split = 1'b1;
            end

            if (st_d.err_code == ERR_NONE) begin
              if (split) begin
                push_o.r0    = make_arg(st_q.content_seen, st_q.content_first,
                                        st_q.content_end, idx);
                push_o.count = 2'd1;
                st_d.content_seen  = 1'b0;
                st_d.content_first = '0;
                st_d.content_end   = '0;
              end else if (!blank) begin
                if (!st_q.content_seen) begin
                  st_d.content_seen  = 1'b1;
                  st_d.content_first = idx;
                end
                st_d.content_end = idx + 1'b1;
              end
            end
          end
        end
      end

      if (last_i) begin
        // Closing result, by priority: held error, empty text, open string,
        // parentheses, brackets, then the final argument.
        if (st_d.err_code != ERR_NONE) begin
          fin_r = make_err(st_d.err_code, st_d.err_pos);
        end else if (st_d.char_index == '0) begin
          fin_r      = '0;
          fin_r.kind = KIND_EMPTY;
        end else if (st_d.inside_quotes) begin
          fin_r = make_err(ERR_OPEN_STRING, '0);
        end else if (st_d.paren_level != '0) begin
          fin_r = make_err(ERR_PARENS, '0);
        end else if (st_d.bracket_level != '0) begin
          fin_r = make_err(ERR_BRACKETS, '0);
        end else begin
          fin_r = make_arg(st_d.content_seen, st_d.content_first, st_d.content_end,
                           st_d.char_index);
        end
        fin_r.text_last = 1'b1;
        if (push_o.count == 2'd1) begin
          push_o.r1    = fin_r;
          push_o.count = 2'd2;
        end else begin
          push_o.r0    = fin_r;
          push_o.count = 2'd1;
        end
        st_d = '0;
      end

      if (push_o.count == 2'd2) begin
        push_o.r1.run_last = 1'b1;
      end else if (push_o.count == 2'd1) begin
        push_o.r0.run_last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

`ifndef ASSERT_OFF
  // A two-result beat is only ever a split argument followed by the text end
  a_two_is_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.count == 2'd2) |-> (push_o.r0.kind == KIND_ARG && push_o.r1.text_last))
    else $error("two results without a split argument and a text end");
`endif

endmodule

// ===== hdl/asp_rfifo.sv =====
// ----------------------------------------------------------------------------
// asp_rfifo: argument splitter result queue
// Small register queue that takes up to two results a cycle and hands out
// one result per output beat.
// ----------------------------------------------------------------------------
module asp_rfifo import asp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  push_t             push_i,
  input  logic              pop_i,
  output logic              valid_o,
  output result_t           head_o,
  output logic [RqCntW-1:0] count_o
);

  result_t             mem_q [RqDepth];
  logic [RqPtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [RqCntW-1:0]   cnt_q, cnt_d;
  logic [RqPtrW-1:0]   wr_next;
  logic                do_pop;

  assign do_pop  = pop_i && (cnt_q != '0);
  assign wr_next = wr_q + 1'b1;
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign count_o = cnt_q;

  always_comb begin
    wr_d  = wr_q + RqPtrW'(push_i.count);
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + RqCntW'(push_i.count) - RqCntW'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_next] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= RqCntW'(RqDepth))
    else $error("result queue overflow");

  a_room_for_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |-> (cnt_q <= RqCntW'(RqDepth - 2)))
    else $error("result pushed without room reserved");
`endif

endmodule

// ===== hdl/top_level_argument_splitter.sv =====
// ----------------------------------------------------------------------------
// top_level_argument_splitter: nesting-aware argument splitter
// Splits an argument-list text at top-level commas and reports trimmed
// argument spans, errors and empty-text markers.
// ----------------------------------------------------------------------------
// Usage
//   in_i carries one byte per beat (character, has_char, last). A beat with
//   has_char low and last low is dropped; has_char low with last high closes
//   the text. out_o carries one result per beat; run_last marks the final
//   result of an input beat and text_last the final result of the text. A
//   text that closes with an error result must have its earlier argument
//   results discarded by the consumer.
//   Each input beat passes the input register and is then parsed into the
//   result queue, whose head drives out_o. Throughput: one input beat per
//   cycle while in_i.ready is high; a comma on the last byte yields two
//   results, which drain at one per output beat.
//   Reset clears the parse state and empties the result queue; the first
//   text starts from index zero.
//   When the receiver stalls, results collect in the eight-entry queue and
//   in_i.ready drops once the queue cannot take two more results from each
//   beat still in flight, so nothing is lost.
// ----------------------------------------------------------------------------
module top_level_argument_splitter import asp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  asp_in_if.sink    in_i,
  asp_out_if.source out_o
);

  // Input register
  logic             in_valid_q;
  logic [CharW-1:0] char_q;
  logic             has_q;
  logic             last_q;
  logic             accept;

  push_t             push;
  result_t           head;
  logic              rq_valid;
  logic [RqCntW-1:0] rq_count;
  logic [RqCntW:0]   room_need;

  // Reserve two queue slots for the beat in the input register and two for
  // a new beat; hold ready low until both fit.
  assign room_need  = {1'b0, rq_count} + (in_valid_q ? (RqCntW+1)'(2) : '0);
  assign in_i.ready = (room_need <= (RqCntW+1)'(RqDepth - 2));
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q <= in_i.character;
      has_q  <= in_i.has_char;
      last_q <= in_i.last;
    end
  end

  asp_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_q),
    .char_i     (char_q),
    .has_i      (has_q),
    .last_i     (last_q),
    .push_o     (push)
  );

  asp_rfifo u_rfifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_o.ready),
    .valid_o (rq_valid),
    .head_o  (head),
    .count_o (rq_count)
  );

  // Drive the result channel from the queue head
  assign out_o.valid          = rq_valid;
  assign out_o.kind           = head.kind;
  assign out_o.arg_start      = head.arg_start;
  assign out_o.arg_length     = head.arg_length;
  assign out_o.error_code     = head.error_code;
  assign out_o.error_position = head.error_position;
  assign out_o.run_last       = head.run_last;
  assign out_o.text_last      = head.text_last;

`ifndef ASSERT_OFF
  a_text_end_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.text_last) |-> out_o.run_last)
    else $error("text end result not marked as last of its beat");
`endif

endmodule
